// File: sv/gflj_pkg.sv
// Shared definitions for the GF(2) LFSR jump-ahead core.
// Holds widths, reset values, command, configuration and status codes, sequencer states and the parity helper.
// No dependencies.
`default_nettype none

package gflj_pkg;

    // Width of the LFSR state and of one matrix row.
    localparam int STATE_BITS = 48;
    localparam int TOP_BIT    = STATE_BITS - 1;
    localparam int ROW_AW     = $clog2(STATE_BITS);
    localparam int DBL_W      = 6;
    localparam int CNT_W      = $clog2(STATE_BITS + 1);

    // Register reset values.
    localparam logic [STATE_BITS-1:0] TAP_RESET = 48'hCE0044C101CD;
    localparam logic [DBL_W-1:0]      DBL_RESET = 6'd26;

    // Command codes carried in the input tuser field.
    localparam logic CMD_REBUILD = 1'b0;
    localparam logic CMD_JUMP    = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_TAP_MASK  = 1'b0;
    localparam logic CFG_DOUBLINGS = 1'b1;

    // Status codes carried in the output tuser field.
    localparam logic [1:0] STAT_JUMP_DONE    = 2'd0;
    localparam logic [1:0] STAT_REBUILD_DONE = 2'd1;
    localparam logic [1:0] STAT_JUMP_RAW     = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_SQROW = 6'b000100,
        S_SQACC = 6'b001000,
        S_JUMP  = 6'b010000,
        S_DONE  = 6'b100000
    } t_fsm;

    // Parity of a full state-width word.
    function automatic logic parity_row(input logic [STATE_BITS-1:0] x);
        parity_row = ^x;
    endfunction

endpackage

`default_nettype wire

// File: sv/gf2_lfsr_jump_ahead_core.sv
// Top level of the GF(2) LFSR jump-ahead core: sequencer, registers, output stage.
// Depends on gflj_pkg and gflj_ram (two instances, ping-pong matrix stores).
//
// Usage:
//   The slave stream takes one item per command: tuser[0] is the command
//   (0 rebuild, 1 jump) and tdata[47:0] the start state. The master stream
//   returns one item per command: tdata[47:0] the new state (zero after a
//   rebuild) and tuser[1:0] the status. The configuration channel writes
//   tap_mask (index 0) and doublings (index 1); it is always ready.
//   A jump reads the 48 matrix rows one per cycle from the matrix RAM and
//   takes the parity of each row AND the state; no new item is accepted
//   until its result has moved to the output register. A jump before any
//   rebuild returns the state unchanged. A rebuild writes the one-step
//   matrix, then squares it doublings times; each squaring walks the 48
//   rows, and for each row b streams all 48 rows from the RAM, XOR-ing
//   each row that a set bit of row b selects into row b of the other RAM.
//   Only one item is in work at a time. A finished result waits in the
//   output register; the next item is accepted meanwhile, and the block
//   holds its next result until the receiver takes the first.
//   Reset clears the sequencer, the output valid and the matrix-ready flag
//   and loads the register reset values; the RAMs are not cleared.
`default_nettype none

module gf2_lfsr_jump_ahead_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input item stream.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [gflj_pkg::STATE_BITS-1:0]  s_axis_tdata,  // [47:0] start_state
    input  wire logic [0:0]                       s_axis_tuser,  // [0] command
    // Result item stream.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [gflj_pkg::STATE_BITS-1:0]  m_axis_tdata,  // [47:0] jumped_state
    output logic      [1:0]                       m_axis_tuser,  // [1:0] status
    // Configuration write channel.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic                             i_cfg_index,
    input  wire logic [gflj_pkg::STATE_BITS-1:0]  i_cfg_data
);

    import gflj_pkg::*;

    t_fsm                  r_fsm;
    logic [STATE_BITS-1:0] r_tap;
    logic [DBL_W-1:0]      r_dbl;
    logic                  r_mready;
    logic                  r_cur;
    logic [CNT_W-1:0]      r_k;
    logic [ROW_AW-1:0]     r_b;
    logic [DBL_W-1:0]      r_sq;
    logic [STATE_BITS-1:0] r_rowb;
    logic [STATE_BITS-1:0] r_acc;
    logic [STATE_BITS-1:0] r_in_state;
    logic [STATE_BITS-1:0] r_res_state;
    logic [1:0]            r_res_status;
    logic                  r_ovalid;
    logic [STATE_BITS-1:0] r_ostate;
    logic [1:0]            r_ostatus;

    logic [CNT_W-1:0]      kd;
    logic                  k_last;
    logic                  rowb_bit;
    logic [ROW_AW-1:0]     rd_addr;
    logic [STATE_BITS-1:0] rd0;
    logic [STATE_BITS-1:0] rd1;
    logic [STATE_BITS-1:0] rd_cur;
    logic [STATE_BITS-1:0] init_row;
    logic [STATE_BITS-1:0] n_acc;
    logic                  wr_row;
    logic                  we0;
    logic                  we1;
    logic [STATE_BITS-1:0] wdata0;
    logic                  in_acc;

    assign s_axis_tready = (r_fsm == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_ostate;
    assign m_axis_tuser  = r_ostatus;

    // Row index of the data returning from the RAM this cycle.
    assign kd       = r_k - CNT_W'(1);
    assign k_last   = (r_k == CNT_W'(STATE_BITS));
    assign rowb_bit = (r_k != '0) && !k_last ? r_rowb[kd[ROW_AW-1:0]] :
                      (k_last ? r_rowb[TOP_BIT] : 1'b0);

    // Shared read address: the row being squared, or the streaming row index.
    always_comb begin
        if (r_fsm == S_SQROW) begin
            rd_addr = r_b;
        end else if (r_k < CNT_W'(STATE_BITS)) begin
            rd_addr = r_k[ROW_AW-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    assign rd_cur = r_cur ? rd1 : rd0;

    // One-step matrix: row b selects state bit b+1, the top row is the tap mask.
    assign init_row = (r_b == ROW_AW'(TOP_BIT)) ? r_tap
                    : (STATE_BITS'(1) << (r_b + ROW_AW'(1)));

    // Squaring accumulator: XOR in row c when bit c of row b is set.
    assign n_acc = r_acc ^ (rowb_bit ? rd_cur : '0);

    // Write steering: init fills RAM 0; squaring writes the other RAM.
    assign wr_row = (r_fsm == S_SQACC) && k_last;
    assign we0    = (r_fsm == S_INIT) || (wr_row && r_cur);
    assign we1    = wr_row && !r_cur;
    assign wdata0 = (r_fsm == S_INIT) ? init_row : n_acc;

    gflj_ram #(.WIDTH(STATE_BITS), .DEPTH(STATE_BITS)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (r_b),
        .i_wdata (wdata0),
        .i_raddr (rd_addr),
        .o_rdata (rd0)
    );

    gflj_ram #(.WIDTH(STATE_BITS), .DEPTH(STATE_BITS)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_b),
        .i_wdata (n_acc),
        .i_raddr (rd_addr),
        .o_rdata (rd1)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= TAP_RESET;
            r_dbl <= DBL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TAP_MASK:  r_tap <= i_cfg_data;
                CFG_DOUBLINGS: r_dbl <= i_cfg_data[DBL_W-1:0];
                default:       r_tap <= r_tap;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_state <= s_axis_tdata;
        end
        if (r_fsm == S_SQACC) begin
            if (r_k == '0) begin
                r_rowb <= rd_cur;
                r_acc  <= '0;
            end else begin
                r_acc <= n_acc;
            end
        end
        if (r_fsm == S_JUMP && r_k != '0) begin
            r_res_state[kd[ROW_AW-1:0]] <= parity_row(rd_cur & r_in_state);
        end else if (in_acc && s_axis_tuser[0] == CMD_JUMP && !r_mready) begin
            r_res_state <= s_axis_tdata;
        end else if (in_acc && s_axis_tuser[0] == CMD_REBUILD) begin
            r_res_state <= '0;
        end
        if (r_fsm == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ostate  <= r_res_state;
            r_ostatus <= r_res_status;
        end
    end

    // Output valid: set when a result moves into the output register,
    // cleared when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_fsm == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= S_IDLE;
            r_mready     <= 1'b0;
            r_cur        <= 1'b0;
            r_k          <= '0;
            r_b          <= '0;
            r_sq         <= '0;
            r_res_status <= STAT_JUMP_DONE;
        end else begin
            case (r_fsm)
                S_IDLE: begin
                    if (in_acc) begin
                        r_k <= '0;
                        r_b <= '0;
                        if (s_axis_tuser[0] == CMD_REBUILD) begin
                            r_fsm <= S_INIT;
                        end else if (!r_mready) begin
                            r_res_status <= STAT_JUMP_RAW;
                            r_fsm        <= S_DONE;
                        end else begin
                            r_fsm <= S_JUMP;
                        end
                    end
                end
                S_INIT: begin
                    if (r_b == ROW_AW'(TOP_BIT)) begin
                        r_cur <= 1'b0;
                        r_b   <= '0;
                        r_sq  <= '0;
                        if (r_dbl == '0) begin
                            r_mready     <= 1'b1;
                            r_res_status <= STAT_REBUILD_DONE;
                            r_fsm        <= S_DONE;
                        end else begin
                            r_fsm <= S_SQROW;
                        end
                    end else begin
                        r_b <= r_b + ROW_AW'(1);
                    end
                end
                S_SQROW: begin
                    r_k   <= '0;
                    r_fsm <= S_SQACC;
                end
                S_SQACC: begin
                    if (k_last) begin
                        if (r_b == ROW_AW'(TOP_BIT)) begin
                            r_cur <= !r_cur;
                            r_b   <= '0;
                            if (r_sq == r_dbl - DBL_W'(1)) begin
                                r_mready     <= 1'b1;
                                r_res_status <= STAT_REBUILD_DONE;
                                r_fsm        <= S_DONE;
                            end else begin
                                r_sq  <= r_sq + DBL_W'(1);
                                r_fsm <= S_SQROW;
                            end
                        end else begin
                            r_b   <= r_b + ROW_AW'(1);
                            r_fsm <= S_SQROW;
                        end
                    end else begin
                        r_k <= r_k + CNT_W'(1);
                    end
                end
                S_JUMP: begin
                    if (k_last) begin
                        r_res_status <= STAT_JUMP_DONE;
                        r_fsm        <= S_DONE;
                    end else begin
                        r_k <= r_k + CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_fsm <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/gflj_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for both matrix stores of the jump-ahead core. No dependencies.
`default_nettype none

module gflj_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire
